// ===== sv/bqpm_pkg.sv =====
// Package for the clamped biquad plant model.
// Holds fixed-point widths, register indexes and register reset values.
// No dependencies.
package bqpm_pkg;

  // Fixed-point formats: samples Q16.16, coefficients Q4.20
  localparam int SAMPLE_W        = 32;
  localparam int COEFF_W         = 24;
  localparam int COEFF_FRAC_BITS = 20;

  // Product and accumulator widths (five products summed exactly)
  localparam int PROD_W = SAMPLE_W + COEFF_W;
  localparam int ACC_W  = PROD_W + 3;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEFF_B0   = 3'd0;
  localparam cfg_idx_t REG_COEFF_B1   = 3'd1;
  localparam cfg_idx_t REG_COEFF_B2   = 3'd2;
  localparam cfg_idx_t REG_COEFF_A1   = 3'd3;
  localparam cfg_idx_t REG_COEFF_A2   = 3'd4;
  localparam cfg_idx_t REG_OUTPUT_MAX = 3'd5;
  localparam cfg_idx_t REG_OUTPUT_MIN = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Reset values: default plant coefficients and +/-100.0 output limits
  localparam coeff_t  RST_COEFF_B0   = 24'sd119103;
  localparam coeff_t  RST_COEFF_B1   = 24'sd238205;
  localparam coeff_t  RST_COEFF_B2   = 24'sd119103;
  localparam coeff_t  RST_COEFF_A1   = -24'sd1904683;
  localparam coeff_t  RST_COEFF_A2   = 24'sd858012;
  localparam sample_t RST_OUTPUT_MAX = 32'sd6553600;
  localparam sample_t RST_OUTPUT_MIN = -32'sd6553600;

  // Saturation limits of the truncated sum
  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

endpackage

// ===== sv/biquad_plant_model_clamped.sv =====
// Top level of the clamped biquad plant model (direct form I IIR).
// Depends on bqpm_pkg for widths, register indexes and reset values.
// Throughput is one sample per clock while result_ready stays high: a sample sits in the
// input register while five 24x32 products, their sum, the floor shift, saturation and
// clamping are formed, and the result lands in the output register with the history
// updated at the same edge. Result valid rises when the sample moves from the input
// register into the output register. The next sample is accepted while a result waits,
// and the output register stalls only when the consumer holds result_ready low.
// Coefficients are Q4.20 and samples Q16.16; the history keeps the saturated but
// unclamped output, and clear_history zeroes the history before its sample.
module biquad_plant_model_clamped (
  input  logic                          clk,
  input  logic                          rst,
  // Sample channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bqpm_pkg::sample_t             sample_in,
  input  logic                          clear_history,
  // Result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output bqpm_pkg::sample_t             sample_out,
  // Configuration write port
  input  logic                          cfg_we,
  input  bqpm_pkg::cfg_idx_t            cfg_index,
  input  logic [bqpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bqpm_pkg::*;

  // Configuration registers
  coeff_t  coeff_b0, coeff_b1, coeff_b2, coeff_a1, coeff_a2;
  sample_t output_max, output_min;

  // Input register
  logic    stage_valid;
  sample_t stage_sample;
  logic    stage_clear;

  // History
  sample_t input_delay_one, input_delay_two;
  sample_t output_delay_one, output_delay_two;

  // Datapath
  logic    advance;
  sample_t x1_eff, x2_eff, y1_eff, y2_eff;
  prod_t   prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
  acc_t    acc;
  acc_t    acc_shift;
  sample_t y_sat;
  sample_t y_hi;
  sample_t y_clamp;

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_b0   <= RST_COEFF_B0;
      coeff_b1   <= RST_COEFF_B1;
      coeff_b2   <= RST_COEFF_B2;
      coeff_a1   <= RST_COEFF_A1;
      coeff_a2   <= RST_COEFF_A2;
      output_max <= RST_OUTPUT_MAX;
      output_min <= RST_OUTPUT_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEFF_B0:   coeff_b0   <= cfg_data[COEFF_W-1:0];
        REG_COEFF_B1:   coeff_b1   <= cfg_data[COEFF_W-1:0];
        REG_COEFF_B2:   coeff_b2   <= cfg_data[COEFF_W-1:0];
        REG_COEFF_A1:   coeff_a1   <= cfg_data[COEFF_W-1:0];
        REG_COEFF_A2:   coeff_a2   <= cfg_data[COEFF_W-1:0];
        REG_OUTPUT_MAX: output_max <= cfg_data[SAMPLE_W-1:0];
        REG_OUTPUT_MIN: output_min <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the staged sample when the output register is free or being drained
  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  // Capture an incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_sample <= sample_in;
      stage_clear  <= clear_history;
    end
  end

  // Drop history for a sample flagged to clear it
  assign x1_eff = stage_clear ? '0 : input_delay_one;
  assign x2_eff = stage_clear ? '0 : input_delay_two;
  assign y1_eff = stage_clear ? '0 : output_delay_one;
  assign y2_eff = stage_clear ? '0 : output_delay_two;

  // Form the five products and their exact sum
  always_comb begin
    prod_b0 = coeff_b0 * stage_sample;
    prod_b1 = coeff_b1 * x1_eff;
    prod_b2 = coeff_b2 * x2_eff;
    prod_a1 = coeff_a1 * y1_eff;
    prod_a2 = coeff_a2 * y2_eff;
    acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
        - ACC_W'(prod_a1) - ACC_W'(prod_a2);
  end

  // Truncate toward minus infinity, then saturate to 32 bits
  always_comb begin
    acc_shift = acc >>> COEFF_FRAC_BITS;
    if (acc_shift > ACC_W'(SAMPLE_MAX)) begin
      y_sat = SAMPLE_MAX;
    end else if (acc_shift < ACC_W'(SAMPLE_MIN)) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = acc_shift[SAMPLE_W-1:0];
    end
  end

  // Limit to output_max first, then raise to output_min
  always_comb begin
    y_hi    = (y_sat < output_max) ? y_sat : output_max;
    y_clamp = (y_hi > output_min) ? y_hi : output_min;
  end

  // Shift history as the sample retires
  always_ff @(posedge clk) begin
    if (rst) begin
      input_delay_one  <= '0;
      input_delay_two  <= '0;
      output_delay_one <= '0;
      output_delay_two <= '0;
    end else if (advance) begin
      input_delay_one  <= stage_sample;
      input_delay_two  <= x1_eff;
      output_delay_one <= y_sat;
      output_delay_two <= y1_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y_clamp;
    end
  end

endmodule

// ===== dv/plant_output_checker.sv =====
// Checker for the clamped biquad plant model: watches the sample, result and
// register-write ports, predicts each output and compares it with the block's.
// Depends on bqpm_pkg for widths, register indexes and reset values.
module plant_output_checker
  import bqpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  sample_t               sample_in,
  input  logic                  clear_history,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  sample_t               sample_out,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // Shadow registers and filter history
  coeff_t  gain_b0, gain_b1, gain_b2, gain_a1, gain_a2;
  sample_t limit_hi, limit_lo;
  sample_t x_prev1, x_prev2, y_prev1, y_prev2;

  // Clamped outputs still owed by the block, oldest first
  sample_t expected_outputs[$];

  int fails = 0;

  assign fail_count = fails;

  // Advance the filter by one sample and return the clamped output
  function automatic sample_t plant_response(sample_t x, logic clr);
    longint  acc;
    longint  y_full;
    sample_t y_sat;
    sample_t y_out;
    if (clr) begin
      x_prev1 = '0;
      x_prev2 = '0;
      y_prev1 = '0;
      y_prev2 = '0;
    end
    acc = longint'(gain_b0) * longint'(x)
        + longint'(gain_b1) * longint'(x_prev1)
        + longint'(gain_b2) * longint'(x_prev2)
        - longint'(gain_a1) * longint'(y_prev1)
        - longint'(gain_a2) * longint'(y_prev2);
    // Floor to Q16.16, then saturate to 32 bits
    y_full = acc >>> COEFF_FRAC_BITS;
    if (y_full > longint'(SAMPLE_MAX)) begin
      y_sat = SAMPLE_MAX;
    end else if (y_full < longint'(SAMPLE_MIN)) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = sample_t'(y_full);
    end
    x_prev2 = x_prev1;
    x_prev1 = x;
    y_prev2 = y_prev1;
    y_prev1 = y_sat;
    // Upper limit first, lower limit wins when the two cross
    y_out = (y_sat < limit_hi) ? y_sat : limit_hi;
    y_out = (y_out > limit_lo) ? y_out : limit_lo;
    return y_out;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      gain_b0  = RST_COEFF_B0;
      gain_b1  = RST_COEFF_B1;
      gain_b2  = RST_COEFF_B2;
      gain_a1  = RST_COEFF_A1;
      gain_a2  = RST_COEFF_A2;
      limit_hi = RST_OUTPUT_MAX;
      limit_lo = RST_OUTPUT_MIN;
      x_prev1  = '0;
      x_prev2  = '0;
      y_prev1  = '0;
      y_prev2  = '0;
      expected_outputs.delete();
    end else begin
      // Track register writes; drop writes to unused indexes
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_B0:   gain_b0  = coeff_t'(cfg_data[COEFF_W-1:0]);
          REG_COEFF_B1:   gain_b1  = coeff_t'(cfg_data[COEFF_W-1:0]);
          REG_COEFF_B2:   gain_b2  = coeff_t'(cfg_data[COEFF_W-1:0]);
          REG_COEFF_A1:   gain_a1  = coeff_t'(cfg_data[COEFF_W-1:0]);
          REG_COEFF_A2:   gain_a2  = coeff_t'(cfg_data[COEFF_W-1:0]);
          REG_OUTPUT_MAX: limit_hi = sample_t'(cfg_data);
          REG_OUTPUT_MIN: limit_lo = sample_t'(cfg_data);
          default: ;
        endcase
      end
      // Check a result transaction against the oldest prediction
      if (result_valid && result_ready) begin
        if (expected_outputs.size() == 0) begin
          $error("sample_out: expected none, got %0d", sample_out);
          fails++;
        end else begin
          want = expected_outputs.pop_front();
          if (sample_out !== want) begin
            $error("sample_out: expected %0d, got %0d", want, sample_out);
            fails++;
          end
        end
      end
      // Predict the output of a sample transaction
      if (item_valid && item_ready) begin
        expected_outputs.push_back(plant_response(sample_in, clear_history));
      end
    end
    pending = expected_outputs.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the clamped biquad plant model: drives samples, register
// writes and output back-pressure, and reports the verdict.
// Depends on bqpm_pkg, biquad_plant_model_clamped and plant_output_checker.
module tb_top;
  import bqpm_pkg::*;

  localparam int       WATCHDOG_LIMIT = 1000;
  localparam int       SETTLE_CYCLES  = 4;
  localparam int       PHASE_ITEMS    = 106;
  localparam int       NUM_PHASES     = 8;
  localparam cfg_idx_t REG_UNUSED     = 3'd7;
  // 2.5 in Q16.16, the usual step drive of the plant
  localparam sample_t  STEP_DRIVE     = 32'sd163840;
  // 200.0 in Q16.16, span of the ordinary drive samples
  localparam int       DRIVE_SPAN     = 13107200;

  typedef enum int {
    PROFILE_PLANT,
    PROFILE_GENTLE,
    PROFILE_EXTREME,
    PROFILE_CROSSED,
    PROFILE_WILD
  } profile_e;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  item_valid    = 1'b0;
  sample_t               sample_in     = '0;
  logic                  clear_history = 1'b0;
  logic                  result_ready  = 1'b0;
  logic                  cfg_we        = 1'b0;
  cfg_idx_t              cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  item_ready;
  logic                  result_valid;
  sample_t               sample_out;
  int                    fail_count;
  int                    pending;
  bit                    steady        = 1'b0;

  biquad_plant_model_clamped u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .sample_in     (sample_in),
    .clear_history (clear_history),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .sample_out    (sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  plant_output_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .sample_in     (sample_in),
    .clear_history (clear_history),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .sample_out    (sample_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random outside steady stretches
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Present one sample and hold it until the transaction completes
  task automatic send_item(input sample_t x, input logic clr);
    while (!steady && $urandom_range(99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    sample_in     <= x;
    clear_history <= clr;
    do @(posedge clk); while (!item_ready);
  endtask

  // Write one register; the caller lowers the write enable after a batch
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] b0, b1, b2, a1, a2, hi, lo);
    write_reg(REG_COEFF_B0, b0);
    write_reg(REG_COEFF_B1, b1);
    write_reg(REG_COEFF_B2, b2);
    write_reg(REG_COEFF_A1, a1);
    write_reg(REG_COEFF_A2, a2);
    write_reg(REG_OUTPUT_MAX, hi);
    write_reg(REG_OUTPUT_MIN, lo);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every predicted output has come back
  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Gain of at most one in magnitude, with junk above the coefficient width
  function automatic logic [CFG_DATA_W-1:0] gentle_gain();
    logic [CFG_DATA_W-1:0] d;
    int                    g;
    d = $urandom;
    g = int'($urandom_range(2097152)) - 1048576;
    d[COEFF_W-1:0] = g[COEFF_W-1:0];
    return d;
  endfunction

  task automatic configure(input profile_e p);
    case (p)
      PROFILE_PLANT: begin
        program_regs(RST_COEFF_B0, RST_COEFF_B1, RST_COEFF_B2, RST_COEFF_A1,
                     RST_COEFF_A2, RST_OUTPUT_MAX, RST_OUTPUT_MIN);
      end
      PROFILE_GENTLE: begin
        program_regs(gentle_gain(), gentle_gain(), gentle_gain(), gentle_gain(),
                     gentle_gain(), $urandom_range(DRIVE_SPAN),
                     -$urandom_range(DRIVE_SPAN));
      end
      PROFILE_EXTREME: begin
        program_regs(32'h007F_FFFF, 32'hFF80_0000, 32'h007F_FFFF, 32'hFF80_0000,
                     32'h007F_FFFF, SAMPLE_MAX, SAMPLE_MIN);
      end
      PROFILE_CROSSED: begin
        program_regs(RST_COEFF_B0, RST_COEFF_B1, RST_COEFF_B2, RST_COEFF_A1,
                     RST_COEFF_A2, -32'sd655360, 32'sd655360);
      end
      default: begin
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
      end
    endcase
  endtask

  // Mix held step drives, moderate samples, full-range noise and extremes
  function automatic sample_t draw_sample(input sample_t prev);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) begin
      return prev;
    end else if (r < 65) begin
      return sample_t'(int'($urandom_range(2 * DRIVE_SPAN)) - DRIVE_SPAN);
    end else if (r < 85) begin
      return sample_t'($urandom);
    end
    case ($urandom_range(4))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  task automatic run_phase(input int count);
    sample_t x;
    x = '0;
    repeat (count) begin
      x = draw_sample(x);
      send_item(x, $urandom_range(99) < 6);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients: a write to an unused index must change nothing
    write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    send_item('0, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(STEP_DRIVE, 1'b1);
    repeat (5) send_item(STEP_DRIVE, 1'b0);
    // Small negative sum checks the floor toward minus infinity
    send_item(-1, 1'b1);
    send_item(1, 1'b0);
    wait_idle();

    // Extreme gains drive the sum into saturation both ways
    configure(PROFILE_EXTREME);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b0);
    wait_idle();

    // Crossed limits pin every output to the lower limit
    configure(PROFILE_CROSSED);
    send_item('0, 1'b1);
    send_item(STEP_DRIVE, 1'b0);
    send_item(-STEP_DRIVE, 1'b0);
    wait_idle();

    // Random phases, one register profile each; one phase without idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      steady <= (ph == 3);
      configure(profile_e'(ph % 5));
      run_phase(PHASE_ITEMS);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
